// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property on the rising clock edge, disabled while reset is low.
`define MTEE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("Port check failed.");

// Asserts that an expression never holds on a rising clock edge out of reset.
`define MTEE_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("Forbidden condition seen.");

`endif

// ----- hw/rtl/mtee_pkg.sv -----
// Package with shared types, codes and constants of the timer expiry engine.
package mtee_pkg;

    localparam int NUM_TIMERS_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int ID_W           = 6;
    localparam int DUR_W          = 30;
    localparam int COUNT_W        = 7;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_START   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_DESTROY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_IDLE    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TIME_W-1:0] op_a;
        logic [TIME_W-1:0] op_b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] sum;
        logic              eq;
    } alu_rsp_t;

endpackage

// ----- hw/rtl/mtee_timeout_ram.sv -----
// Timeout memory: one write port and one registered read port.
module mtee_timeout_ram
    import mtee_pkg::*;
#(
    parameter int DEPTH  = NUM_TIMERS_DEF,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/mtee_alu.sv -----
// Shared 32-bit adder and equality comparator used by the sequencer.
module mtee_alu
    import mtee_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    assign rsp.sum = req.op_a + req.op_b;
    assign rsp.eq  = (req.op_a == req.op_b);

endmodule

// ----- hw/rtl/mtee_seq.sv -----
// Sequencer that runs commands and the per-tick expiry scan over the timers.
module mtee_seq
    import mtee_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int IDX_W      = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_action,
    input  logic [ID_W-1:0]    in_timer_id,
    input  logic [DUR_W-1:0]   in_duration,
    output logic               out_valid,
    input  logic               out_ready,
    output kind_t              out_kind,
    output logic [ID_W-1:0]    out_timer_id,
    output logic               out_was_running,
    output logic [COUNT_W-1:0] out_running_count,
    output logic               out_last,
    output logic               ram_wr_en,
    output logic [IDX_W-1:0]   ram_wr_addr,
    output logic [TIME_W-1:0]  ram_wr_data,
    output logic [IDX_W-1:0]   ram_rd_addr,
    input  logic [TIME_W-1:0]  ram_rd_data,
    output alu_req_t           alu_req,
    input  alu_rsp_t           alu_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_FLUSH,
        S_CMD
    } state_t;

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [ID_W:0]      NUM_ID   = (ID_W + 1)'(NUM_TIMERS);

    state_t               state_reg, state_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [COUNT_W-1:0]   pend_count_reg, pend_count_next;
    action_t              action_reg, action_next;
    logic [ID_W-1:0]      cmd_id_reg, cmd_id_next;
    logic [DUR_W-1:0]     dur_reg, dur_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_was_reg, out_was_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 hit;
    logic                 in_range;
    logic                 was;
    logic [IDX_W-1:0]     cmd_idx;
    logic [DUR_W-1:0]     dur_eff;

    assign out_free = !out_valid_reg || out_ready;
    assign in_range = ({1'b0, cmd_id_reg} < NUM_ID);
    assign cmd_idx  = cmd_id_reg[IDX_W-1:0];
    assign dur_eff  = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
    assign hit      = running_reg[idx_reg] && alu_rsp.eq;
    assign was      = in_range && running_reg[cmd_idx];

    always_comb begin
        state_next      = state_reg;
        time_next       = time_reg;
        running_next    = running_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_count_next = pend_count_reg;
        action_next     = action_reg;
        cmd_id_next     = cmd_id_reg;
        dur_next        = dur_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_was_next    = out_was_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cmd_idx;
        ram_wr_data     = alu_rsp.sum;
        ram_rd_addr     = idx_reg;
        alu_req.op_a    = time_reg;
        alu_req.op_b    = TIME_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    action_next = action_t'(in_action);
                    cmd_id_next = in_timer_id;
                    dur_next    = in_duration;
                    state_next  = (action_t'(in_action) == ACT_TICK) ? S_TICK : S_CMD;
                end
            end
            S_TICK: begin
                time_next       = alu_rsp.sum;
                idx_next        = '0;
                ram_rd_addr     = '0;
                pend_valid_next = 1'b0;
                state_next      = S_SCAN;
            end
            S_SCAN: begin
                alu_req.op_a = ram_rd_data;
                alu_req.op_b = time_reg;
                if (hit && pend_valid_reg && !out_free) begin
                    ram_rd_addr = idx_reg;
                end else begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_EXPIRED;
                            out_id_next    = pend_id_reg;
                            out_was_next   = 1'b0;
                            out_count_next = pend_count_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next       = 1'b1;
                        pend_id_next          = ID_W'(idx_reg);
                        pend_count_next       = total_reg - COUNT_W'(1);
                        total_next            = total_reg - COUNT_W'(1);
                        running_next[idx_reg] = 1'b0;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next    = idx_reg + IDX_W'(1);
                        ram_rd_addr = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_was_next   = 1'b0;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_kind_next  = KIND_EXPIRED;
                        out_id_next    = pend_id_reg;
                        out_count_next = pend_count_reg;
                    end else begin
                        out_kind_next  = KIND_IDLE;
                        out_id_next    = '0;
                        out_count_next = total_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CMD: begin
                alu_req.op_b = TIME_W'(dur_eff);
                if (out_free) begin
                    if (in_range) begin
                        unique case (action_reg)
                            ACT_START: begin
                                ram_wr_en             = 1'b1;
                                running_next[cmd_idx] = 1'b1;
                                total_next = total_reg - COUNT_W'(was) + COUNT_W'(1);
                            end
                            ACT_DESTROY: begin
                                ram_wr_en             = 1'b1;
                                ram_wr_data           = '0;
                                running_next[cmd_idx] = 1'b0;
                                total_next            = total_reg - COUNT_W'(was);
                            end
                            default: begin
                                running_next[cmd_idx] = 1'b0;
                                total_next            = total_reg - COUNT_W'(was);
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_id_next    = cmd_id_reg;
                    out_was_next   = was;
                    out_count_next = total_next;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            time_reg       <= '0;
            running_reg    <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            running_reg    <= running_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        idx_reg        <= idx_next;
        pend_id_reg    <= pend_id_next;
        pend_count_reg <= pend_count_next;
        action_reg     <= action_next;
        cmd_id_reg     <= cmd_id_next;
        dur_reg        <= dur_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_was_reg    <= out_was_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign out_kind          = out_kind_reg;
    assign out_timer_id      = out_id_reg;
    assign out_was_running   = out_was_reg;
    assign out_running_count = out_count_reg;
    assign out_last          = out_last_reg;

endmodule

// ----- hw/rtl/multi_timer_expiry_engine_top.sv -----
// Top level of the multi-timer expiry engine.
//
// Requests arrive on the s_ stream: a tick, or a start, stop or destroy of one
// timer. Results leave on the m_ stream; m_tlast marks the last result of a
// request and m_tuser tells whether it is an acknowledgement, an expiry or a
// tick without expiry.
// A start, stop or destroy request passes through the S_CMD state, which waits
// until the output register is free and then loads one acknowledgement into
// it; the block is ready again in that same cycle.
// A tick request walks the timeout memory through its single read port, one
// entry per cycle unless the scan is held for a free output register, and
// expiries are reported in ascending timer order. One request is in work at a time.
// When the receiver stalls, the result is held in the output register; a tick
// scan parks one expiry beside the output register and stops at the next
// expiry until the output register is free.
// Reset stops all timers and clears the time and the running count. The
// timeout memory needs no clearing pass, since an entry is only compared while
// its timer runs, and every running timer has written its entry.
module multi_timer_expiry_engine_top
    import mtee_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: action[1:0], timer_id[7:2], duration[37:8], zero pad.
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: timer_id_out[5:0], was_running[6], running_count[13:7],
    // zero pad.
    output logic [15:0] m_tdata,
    // Fields from bit 0: kind[1:0].
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [TIME_W-1:0]  ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [TIME_W-1:0]  ram_rd_data;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    kind_t              out_kind;
    logic [ID_W-1:0]    out_timer_id;
    logic               out_was_running;
    logic [COUNT_W-1:0] out_running_count;

    mtee_timeout_ram #(
        .DEPTH  (NUM_TIMERS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mtee_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    mtee_seq #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_seq (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_action         (s_tdata[1:0]),
        .in_timer_id       (s_tdata[7:2]),
        .in_duration       (s_tdata[37:8]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_kind          (out_kind),
        .out_timer_id      (out_timer_id),
        .out_was_running   (out_was_running),
        .out_running_count (out_running_count),
        .out_last          (m_tlast),
        .ram_wr_en         (ram_wr_en),
        .ram_wr_addr       (ram_wr_addr),
        .ram_wr_data       (ram_wr_data),
        .ram_rd_addr       (ram_rd_addr),
        .ram_rd_data       (ram_rd_data),
        .alu_req           (alu_req),
        .alu_rsp           (alu_rsp)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {2'b00, out_running_count, out_was_running, out_timer_id};

endmodule

// ----- hw/rtl/mtee_checker.sv -----
// Port checker for the timer expiry engine and its bind to the top level.
`include "assert_macros.svh"

module mtee_checker
    import mtee_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `MTEE_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `MTEE_ASSERT(a_result_held, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `MTEE_NEVER(a_single_result_not_last, aclk, aresetn,
        m_tvalid && !m_tlast && (m_tuser == KIND_ACK || m_tuser == KIND_IDLE))
    `MTEE_NEVER(a_idle_with_open_run, aclk, aresetn, s_tready && m_tvalid && !m_tlast)
    `MTEE_NEVER(a_bad_kind, aclk, aresetn, m_tvalid && m_tuser == 2'd3)

endmodule

bind multi_timer_expiry_engine_top mtee_checker u_mtee_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- sim/mtee_expiry_monitor.sv -----
// Stream monitor for the timer expiry engine: predicts every result and compares it.
module mtee_expiry_monitor
    import mtee_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // Fields from bit 0: action[1:0], timer_id[7:2], duration[37:8], zero pad.
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: timer_id_out[5:0], was_running[6], running_count[13:7],
    // zero pad.
    input  logic [15:0] m_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          reports_due,
    output int          reports_checked,
    output int          expiries_seen
);

    typedef enum logic [1:0] {
        TMR_STOPPED = 2'd0,
        TMR_RUNNING = 2'd1,
        TMR_EXPIRED = 2'd2
    } timer_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic               was_running;
        logic [COUNT_W-1:0] live;
        logic               last;
    } timer_report_t;

    logic [TIME_W-1:0]  now_ticks;
    logic [TIME_W-1:0]  deadline [64];
    timer_state_t       tstate [64];
    logic [COUNT_W-1:0] live_count;
    timer_report_t      rep_fifo [128];
    logic [6:0]         rep_wr_ptr;
    logic [6:0]         rep_rd_ptr;
    int                 rep_fill;

    task automatic report(input string what, input longint want, input longint got);
        fail_count++;
        $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
    endtask

    task automatic store_report(input timer_report_t rep);
        rep_fifo[rep_wr_ptr] = rep;
        rep_wr_ptr = rep_wr_ptr + 7'd1;
        rep_fill++;
    endtask

    task automatic advance_timers(input logic [39:0] req);
        action_t         act;
        logic [ID_W-1:0] id;
        logic [DUR_W-1:0] dur;
        int              last_hit;
        logic            was;
        timer_report_t   rep;
        act = action_t'(req[1:0]);
        id  = req[7:2];
        dur = req[37:8];
        if (act == ACT_TICK) begin
            now_ticks = now_ticks + 1'b1;
            last_hit = -1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (tstate[i] == TMR_RUNNING && deadline[i] == now_ticks) last_hit = i;
            end
            if (last_hit < 0) begin
                rep = '{KIND_IDLE, '0, 1'b0, live_count, 1'b1};
                store_report(rep);
            end else begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (tstate[i] == TMR_RUNNING && deadline[i] == now_ticks) begin
                        tstate[i] = TMR_EXPIRED;
                        if (live_count != 0) live_count--;
                        rep = '{KIND_EXPIRED, ID_W'(i), 1'b0, live_count, i == last_hit};
                        store_report(rep);
                    end
                end
            end
        end else if (int'(id) >= NUM_TIMERS) begin
            rep = '{KIND_ACK, id, 1'b0, live_count, 1'b1};
            store_report(rep);
        end else begin
            was = (tstate[id] == TMR_RUNNING);
            if (was) begin
                tstate[id] = TMR_STOPPED;
                if (live_count != 0) live_count--;
            end
            if (act == ACT_START) begin
                deadline[id] = now_ticks + ((dur == '0) ? TIME_W'(1) : TIME_W'(dur));
                tstate[id] = TMR_RUNNING;
                if (live_count < 7'd64) live_count++;
            end else if (act == ACT_DESTROY) begin
                tstate[id] = TMR_STOPPED;
                deadline[id] = '0;
            end
            rep = '{KIND_ACK, id, was, live_count, 1'b1};
            store_report(rep);
        end
    endtask

    task automatic check_report();
        timer_report_t want;
        reports_checked++;
        if (m_tuser == KIND_EXPIRED) expiries_seen++;
        if (rep_fill == 0) begin
            report("result with no request in flight, kind", -1, m_tuser);
        end else begin
            want = rep_fifo[rep_rd_ptr];
            rep_rd_ptr = rep_rd_ptr + 7'd1;
            rep_fill--;
            if (m_tuser != want.kind) report("kind", want.kind, m_tuser);
            if (m_tdata[5:0] != want.id) report("timer id", want.id, m_tdata[5:0]);
            if (m_tdata[6] != want.was_running)
                report("was running", want.was_running, m_tdata[6]);
            if (m_tdata[13:7] != want.live) report("running count", want.live, m_tdata[13:7]);
            if (m_tlast != want.last) report("last flag", want.last, m_tlast);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            now_ticks = '0;
            live_count = '0;
            for (int i = 0; i < 64; i++) begin
                deadline[i] = '0;
                tstate[i] = TMR_STOPPED;
            end
            rep_wr_ptr = '0;
            rep_rd_ptr = '0;
            rep_fill = 0;
            fail_count = 0;
            reports_checked = 0;
            expiries_seen = 0;
        end else begin
            if (s_tvalid && s_tready) advance_timers(s_tdata);
            if (m_tvalid && m_tready) check_report();
        end
        reports_due = rep_fill;
    end

endmodule

// ----- sim/multi_timer_expiry_engine_top_tb.sv -----
// Testbench top for the timer expiry engine: clock, reset, request stimulus and verdict.
module multi_timer_expiry_engine_top_tb;
    import mtee_pkg::*;

    localparam int TIMERS = NUM_TIMERS_DEF;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    bit steady = 1'b0;
    int fail_count;
    int reports_due;
    int reports_checked;
    int expiries_seen;
    int sent_count [4] = '{0, 0, 0, 0};

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    multi_timer_expiry_engine_top #(
        .NUM_TIMERS(TIMERS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    mtee_expiry_monitor #(
        .NUM_TIMERS(TIMERS)
    ) monitor_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .reports_due    (reports_due),
        .reports_checked(reports_checked),
        .expiries_seen  (expiries_seen)
    );

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    task automatic send_request(input action_t act, input int id, input logic [DUR_W-1:0] dur);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, dur, ID_W'(id), act};
        sent_count[int'(act)]++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reports_due != 0) @(negedge aclk);
    endtask

    task automatic send_random_request();
        int           pick;
        int           id;
        logic [DUR_W-1:0] dur;
        action_t      act;
        pick = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
                dur = DUR_W'($urandom_range(0, 6));
            end
            7, 8: begin
                dur = DUR_W'($urandom_range(0, 60));
            end
            default: begin
                dur = DUR_W'($urandom);
            end
        endcase
        if (pick < 40) act = ACT_TICK;
        else if (pick < 75) act = ACT_START;
        else if (pick < 90) act = ACT_STOP;
        else act = ACT_DESTROY;
        send_request(act, id, dur);
    endtask

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int order [64];
        int j;
        int tmp;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero duration, full duration, restart, stop and destroy in every state,
        // several expiries on one tick, and a tick with nothing due.
        send_request(ACT_TICK, 0, '0);
        send_request(ACT_START, 0, '0);
        send_request(ACT_TICK, 0, '0);
        send_request(ACT_STOP, 0, '0);
        send_request(ACT_START, 63, '1);
        send_request(ACT_START, 21, 30'd2);
        send_request(ACT_START, 42, 30'd2);
        send_request(ACT_START, 5, 30'd1);
        send_request(ACT_START, 5, 30'd2);
        send_request(ACT_TICK, 0, '0);
        send_request(ACT_TICK, 0, '0);
        send_request(ACT_START, 7, 30'd5);
        send_request(ACT_STOP, 7, '0);
        send_request(ACT_STOP, 7, '0);
        send_request(ACT_START, 9, 30'd5);
        send_request(ACT_DESTROY, 9, '0);
        send_request(ACT_DESTROY, 9, '0);
        send_request(ACT_DESTROY, 63, '0);
        send_request(ACT_DESTROY, 5, '0);
        send_request(ACT_START, 12, 30'd1);
        send_request(ACT_TICK, 0, '0);
        drain_results();

        // All timers armed for the same tick, in shuffled order.
        for (int i = 0; i < 64; i++) order[i] = i;
        for (int i = 63; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        steady = 1'b1;
        for (int i = 0; i < 64; i++) send_request(ACT_START, order[i], 30'd2);
        steady = 1'b0;
        send_request(ACT_TICK, 0, '0);
        send_request(ACT_TICK, 0, '0);

        for (int k = 0; k < 35; k++) begin
            if (k == 20) drain_results();
            send_random_request();
        end

        drain_results();
        repeat (TIMERS + 16) @(negedge aclk);
        $display("run: %0d ticks, %0d starts, %0d stops, %0d destroys sent",
                 sent_count[0], sent_count[1], sent_count[2], sent_count[3]);
        $display("run: %0d results compared, %0d of them timer expiries",
                 reports_checked, expiries_seen);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
